// ===== src/rba_pkg.sv =====
package rba_pkg;

    localparam int FIELD_W = 32;
    localparam int CFG_IDX_W = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NUMER_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DENOM_LIMIT = 1'b1;

    localparam logic [FIELD_W-1:0] NUMER_LIMIT_RST = 32'd65535;
    localparam logic [FIELD_W-1:0] DENOM_LIMIT_RST = 32'd65535;

    typedef struct packed {
        logic [FIELD_W-1:0] value_numer;
        logic [FIELD_W-1:0] value_denom;
    } in_item_t;

    typedef struct packed {
        logic [FIELD_W-1:0] approx_numer;
        logic [FIELD_W-1:0] approx_denom;
    } out_item_t;

endpackage

// ===== src/rba_engine.sv =====
module rba_engine #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DATA_WIDTH-1:0] num_in,
    input  logic [DATA_WIDTH-1:0] den_in,
    input  logic [DATA_WIDTH-1:0] lim_n,
    input  logic [DATA_WIDTH-1:0] lim_d,
    input  logic                  take,
    output logic                  busy,
    output logic                  done,
    output logic [DATA_WIDTH-1:0] res_n,
    output logic [DATA_WIDTH-1:0] res_d
);

    localparam int W = DATA_WIDTH;
    localparam int CNT_W = $clog2(DATA_WIDTH);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CHECK  = 3'd1;
    localparam logic [2:0] ST_DIV    = 3'd2;
    localparam logic [2:0] ST_UPDATE = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [W-1:0]     num_reg, num_next;
    logic [W-1:0]     den_reg, den_next;
    logic [W-1:0]     dvd_reg, dvd_next;
    logic [W-1:0]     rem_reg, rem_next;
    logic [W-1:0]     pp_reg, pp_next;
    logic [W-1:0]     pc_reg, pc_next;
    logic [W-1:0]     qp_reg, qp_next;
    logic [W-1:0]     qc_reg, qc_next;
    logic [W-1:0]     accp_reg, accp_next;
    logic [W-1:0]     accq_reg, accq_next;
    logic [W-1:0]     resn_reg, resn_next;
    logic [W-1:0]     resd_reg, resd_next;

    logic [W:0]       rem_sh;
    logic [W:0]       rem_diff;
    logic             qbit;

    assign rem_sh   = {rem_reg, dvd_reg[W-1]};
    assign rem_diff = rem_sh - {1'b0, den_reg};
    assign qbit     = (rem_sh >= {1'b0, den_reg});

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        num_next   = num_reg;
        den_next   = den_reg;
        dvd_next   = dvd_reg;
        rem_next   = rem_reg;
        pp_next    = pp_reg;
        pc_next    = pc_reg;
        qp_next    = qp_reg;
        qc_next    = qc_reg;
        accp_next  = accp_reg;
        accq_next  = accq_reg;
        resn_next  = resn_reg;
        resd_next  = resd_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    num_next   = num_in;
                    den_next   = den_in;
                    pp_next    = '0;
                    pc_next    = W'(1);
                    qp_next    = W'(1);
                    qc_next    = '0;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (pc_reg > lim_n || qc_reg > lim_d)
                begin
                    // newest convergent is out of bounds: fall back one
                    resn_next  = pp_reg;
                    resd_next  = qp_reg;
                    state_next = ST_DONE;
                end
                else if (den_reg == '0)
                begin
                    resn_next  = pc_reg;
                    resd_next  = qc_reg;
                    state_next = ST_DONE;
                end
                else
                begin
                    dvd_next   = num_reg;
                    rem_next   = '0;
                    accp_next  = '0;
                    accq_next  = '0;
                    cnt_next   = CNT_W'(W - 1);
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                // one quotient bit per cycle, MSB first; fold it into quo*p and quo*q
                rem_next  = qbit ? rem_diff[W-1:0] : rem_sh[W-1:0];
                dvd_next  = {dvd_reg[W-2:0], 1'b0};
                accp_next = {accp_reg[W-2:0], 1'b0} + (qbit ? pc_reg : '0);
                accq_next = {accq_reg[W-2:0], 1'b0} + (qbit ? qc_reg : '0);
                cnt_next  = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                num_next   = den_reg;
                den_next   = rem_reg;
                pp_next    = pc_reg;
                pc_next    = pp_reg + accp_reg;
                qp_next    = qc_reg;
                qc_next    = qp_reg + accq_reg;
                state_next = ST_CHECK;
            end
            ST_DONE:
            begin
                if (take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        num_reg  <= num_next;
        den_reg  <= den_next;
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        pp_reg   <= pp_next;
        pc_reg   <= pc_next;
        qp_reg   <= qp_next;
        qc_reg   <= qc_next;
        accp_reg <= accp_next;
        accq_reg <= accq_next;
        resn_reg <= resn_next;
        resd_reg <= resd_next;
    end

    assign busy  = (state_reg != ST_IDLE);
    assign done  = (state_reg == ST_DONE);
    assign res_n = resn_reg;
    assign res_d = resd_reg;

endmodule

// ===== src/rational_best_approximation_top.sv =====
// Channel  Direction  Signals                          Accepted when
// in       input      in_valid, in_stall, in_data      in_valid && !in_stall
// out      output     out_valid, out_stall, out_data   out_valid && !out_stall
// cfg      input      cfg_we, cfg_index, cfg_data      cfg_we
//
// Each continued-fraction term takes a check, a pass through the shared
// restoring divider (one quotient bit per cycle) and an update.
// The result is registered in the engine and handed to the output register once that is free;
// the next item is accepted only after that hand-over.
// in_stall is high while the engine works on an item; one result may wait in
// the output register while the next item is being worked on.
// Reset clears the handshake state and sets both limits to 65535.
module rational_best_approximation_top #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  rba_pkg::in_item_t               in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output rba_pkg::out_item_t              out_data,
    input  logic                            cfg_we,
    input  logic [rba_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rba_pkg::FIELD_W-1:0]     cfg_data
);

    import rba_pkg::*;

    logic [FIELD_W-1:0]    numer_limit_reg;
    logic [FIELD_W-1:0]    denom_limit_reg;
    logic                  out_valid_reg;
    out_item_t             out_data_reg;

    logic                  eng_busy;
    logic                  eng_done;
    logic                  eng_take;
    logic [DATA_WIDTH-1:0] eng_res_n;
    logic [DATA_WIDTH-1:0] eng_res_d;
    logic                  in_fire;

    assign in_stall = eng_busy;
    assign in_fire  = in_valid && !eng_busy;
    // hand the result over once the output register is free or being emptied
    assign eng_take = eng_done && (!out_valid_reg || !out_stall);

    rba_engine #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (in_fire),
        .num_in (DATA_WIDTH'(in_data.value_numer)),
        .den_in (DATA_WIDTH'(in_data.value_denom)),
        .lim_n  (DATA_WIDTH'(numer_limit_reg)),
        .lim_d  (DATA_WIDTH'(denom_limit_reg)),
        .take   (eng_take),
        .busy   (eng_busy),
        .done   (eng_done),
        .res_n  (eng_res_n),
        .res_d  (eng_res_d)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            numer_limit_reg <= NUMER_LIMIT_RST;
            denom_limit_reg <= DENOM_LIMIT_RST;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_NUMER_LIMIT: numer_limit_reg <= cfg_data;
                    CFG_DENOM_LIMIT: denom_limit_reg <= cfg_data;
                    default:         ;
                endcase
            end
            if (eng_take)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (eng_take)
        begin
            out_data_reg.approx_numer <= FIELD_W'(eng_res_n);
            out_data_reg.approx_denom <= FIELD_W'(eng_res_d);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
